@@ src/tcsm_pkg.sv @@
// Package for the TCP close-path state machine: event, status, segment and
// phase codes, frame-check constants, and the item and result structs.
// No dependencies.
package tcsm_pkg;

  // Event codes carried in the input tuser.
  localparam logic [1:0] EV_ESTABLISH = 2'd0;
  localparam logic [1:0] EV_APP_CLOSE = 2'd1;
  localparam logic [1:0] EV_PEER_FIN  = 2'd2;
  localparam logic [1:0] EV_PEER_ACK  = 2'd3;

  // Connection phases.
  localparam logic [2:0] PH_CLOSED    = 3'd0;
  localparam logic [2:0] PH_ESTAB     = 3'd1;
  localparam logic [2:0] PH_FIN_WAIT1 = 3'd2;
  localparam logic [2:0] PH_FIN_WAIT2 = 3'd3;
  localparam logic [2:0] PH_CLOSING   = 3'd4;
  localparam logic [2:0] PH_TIME_WAIT = 3'd5;
  localparam logic [2:0] PH_CLOSE_WAIT = 3'd6;
  localparam logic [2:0] PH_LAST_ACK  = 3'd7;

  // Result status codes.
  localparam logic [1:0] ST_IGNORED   = 2'd0;
  localparam logic [1:0] ST_APPLIED   = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_OUT_SEQ   = 2'd3;

  // Segment kinds to transmit.
  localparam logic [1:0] SK_NONE    = 2'd0;
  localparam logic [1:0] SK_ACK     = 2'd1;
  localparam logic [1:0] SK_FIN_ACK = 2'd2;

  // Frame-check constants in bytes.
  localparam logic [16:0] ETH_BYTES     = 17'd14;
  localparam logic [16:0] MIN_HDR_BYTES = 17'd20;
  localparam logic [16:0] MIN_FRAME_BYTES = ETH_BYTES + MIN_HDR_BYTES + MIN_HDR_BYTES;
  localparam logic [31:0] ONE_SEQ       = 32'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] frame_len;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_offset_words;
    logic [15:0] ip_total_length;
    logic [31:0] segment_seq;
    logic [31:0] now_ms;
    logic [31:0] start_send_next;
    logic [31:0] start_recv_next;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  send_kind;
    logic [31:0] send_seq;
    logic [31:0] send_ack;
    logic [2:0]  conn_state;
    logic        conn_live;
    logic        freed;
    logic        close_report;
    logic [31:0] time_wait_stamp;
  } result_t;

endpackage

@@ src/tcp_close_state_machine_top.sv @@
// Top level of the TCP close-path state machine for one connection slot.
// Instantiates tcsm_in_stage, tcsm_engine and tcsm_result_stage; uses tcsm_pkg.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: event mode; tdata: frame and segment fields
//   m_axis    out        tuser: segment kind; tdata: status, numbers, state
//
// An item is accepted into the input register and evaluated while it is held
// and the result register can load, when the engine updates the connection state
// and loads the result register; one item a cycle while the output does not stall.
// Reset clears the connection to closed, not live, with all numbers zero.
// When the output stalls, the result register and the engine hold, and
// tready drops as soon as the input register holds an item.
module tcp_close_state_machine_top (
  input  logic         clk_i,
  input  logic         rst_ni,

  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [15:0] frame_len, [19:16] ip_header_words, [23:20] tcp_offset_words,
  // [39:24] ip_total_length, [71:40] segment_seq, [103:72] now_ms,
  // [135:104] start_send_next, [167:136] start_recv_next
  input  logic [167:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]   s_axis_tuser_i,

  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [1:0] status, [33:2] send_seq, [65:34] send_ack, [68:66] conn_state,
  // [69] conn_live, [70] freed, [71] close_report, [103:72] time_wait_stamp
  output logic [103:0] m_axis_tdata_o,
  // [1:0] send_kind
  output logic [1:0]   m_axis_tuser_o
);

  tcsm_pkg::item_t   in_item;
  tcsm_pkg::item_t   held_item;
  tcsm_pkg::result_t next_result;
  tcsm_pkg::result_t out_result;
  logic              held_valid;
  logic              can_load;
  logic              fire;

  // Unpack the stream payload into the item fields.
  always_comb begin
    in_item.mode             = s_axis_tuser_i;
    in_item.frame_len        = s_axis_tdata_i[15:0];
    in_item.ip_header_words  = s_axis_tdata_i[19:16];
    in_item.tcp_offset_words = s_axis_tdata_i[23:20];
    in_item.ip_total_length  = s_axis_tdata_i[39:24];
    in_item.segment_seq      = s_axis_tdata_i[71:40];
    in_item.now_ms           = s_axis_tdata_i[103:72];
    in_item.start_send_next  = s_axis_tdata_i[135:104];
    in_item.start_recv_next  = s_axis_tdata_i[167:136];
  end

  // The engine commits an item when one is held and the result register
  // is free or being emptied in this cycle.
  assign fire = held_valid && can_load;

  tcsm_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .take_i       (fire),
    .held_valid_o (held_valid),
    .held_item_o  (held_item)
  );

  tcsm_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (held_item),
    .result_o (next_result)
  );

  tcsm_result_stage u_result_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (next_result),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (out_result)
  );

  // Pack the result fields onto the output stream.
  assign m_axis_tuser_o = out_result.send_kind;
  assign m_axis_tdata_o = {out_result.time_wait_stamp,
                           out_result.close_report,
                           out_result.freed,
                           out_result.conn_live,
                           out_result.conn_state,
                           out_result.send_ack,
                           out_result.send_seq,
                           out_result.status};

endmodule

@@ src/tcsm_in_stage.sv @@
// Input register for the TCP close-path state machine: holds one accepted
// item until the engine consumes it. Depends on tcsm_pkg.
module tcsm_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tcsm_pkg::item_t in_item_i,
  input  logic            take_i,
  output logic            held_valid_o,
  output tcsm_pkg::item_t held_item_o
);

  logic            valid_q;
  tcsm_pkg::item_t item_q;

  // The register can load whenever it is empty or being drained this cycle.
  assign in_ready_o   = !valid_q || take_i;
  assign held_valid_o = valid_q;
  assign held_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

@@ src/tcsm_engine.sv @@
// Connection state registers and the per-event next-state and result logic
// of the TCP close-path state machine. Depends on tcsm_pkg.
module tcsm_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  tcsm_pkg::item_t   item_i,
  output tcsm_pkg::result_t result_o
);

  logic [2:0]  phase_q, phase_d;
  logic        live_q, live_d;
  logic [31:0] send_next_q, send_next_d;
  logic [31:0] recv_next_q, recv_next_d;
  logic [31:0] linger_q, linger_d;

  logic [5:0]  ihl_bytes;
  logic [5:0]  doff_bytes;
  logic        malformed;
  logic [31:0] payload_len;
  logic [31:0] fin_at;
  logic [31:0] recv_plus_one;

  assign ihl_bytes     = {item_i.ip_header_words, 2'b00};
  assign doff_bytes    = {item_i.tcp_offset_words, 2'b00};
  assign malformed     = ({1'b0, item_i.frame_len} < tcsm_pkg::MIN_FRAME_BYTES)
                      || ({11'd0, ihl_bytes} < tcsm_pkg::MIN_HDR_BYTES)
                      || ({1'b0, item_i.frame_len} < tcsm_pkg::ETH_BYTES
                          + {11'd0, ihl_bytes} + tcsm_pkg::MIN_HDR_BYTES);
  // Payload length wraps modulo 2^32 when the headers exceed the total length.
  assign payload_len   = {16'd0, item_i.ip_total_length} - {26'd0, ihl_bytes}
                       - {26'd0, doff_bytes};
  assign fin_at        = item_i.segment_seq + payload_len;
  assign recv_plus_one = recv_next_q + tcsm_pkg::ONE_SEQ;

  always_comb begin
    phase_d     = phase_q;
    live_d      = live_q;
    send_next_d = send_next_q;
    recv_next_d = recv_next_q;
    linger_d    = linger_q;
    result_o    = '0;
    result_o.status = tcsm_pkg::ST_IGNORED;

    if (item_i.mode == tcsm_pkg::EV_ESTABLISH) begin
      send_next_d     = item_i.start_send_next;
      recv_next_d     = item_i.start_recv_next;
      phase_d         = tcsm_pkg::PH_ESTAB;
      live_d          = 1'b1;
      result_o.status = tcsm_pkg::ST_APPLIED;
    end else if (live_q) begin
      unique case (item_i.mode)
        tcsm_pkg::EV_APP_CLOSE: begin
          result_o.status = tcsm_pkg::ST_APPLIED;
          if (phase_q == tcsm_pkg::PH_ESTAB || phase_q == tcsm_pkg::PH_CLOSE_WAIT) begin
            result_o.send_kind = tcsm_pkg::SK_FIN_ACK;
            result_o.send_seq  = send_next_q;
            result_o.send_ack  = recv_next_q;
            send_next_d        = send_next_q + tcsm_pkg::ONE_SEQ;
            phase_d = (phase_q == tcsm_pkg::PH_ESTAB) ? tcsm_pkg::PH_FIN_WAIT1
                                                      : tcsm_pkg::PH_LAST_ACK;
          end else begin
            result_o.freed        = 1'b1;
            result_o.close_report = 1'b1;
            phase_d     = tcsm_pkg::PH_CLOSED;
            live_d      = 1'b0;
            send_next_d = '0;
            recv_next_d = '0;
            linger_d    = '0;
          end
        end
        tcsm_pkg::EV_PEER_FIN: begin
          priority if (malformed) begin
            result_o.status = tcsm_pkg::ST_MALFORMED;
          end else if (fin_at != recv_next_q) begin
            result_o.status = tcsm_pkg::ST_OUT_SEQ;
          end else if (phase_q == tcsm_pkg::PH_ESTAB || phase_q == tcsm_pkg::PH_FIN_WAIT1
                       || phase_q == tcsm_pkg::PH_FIN_WAIT2) begin
            result_o.status    = tcsm_pkg::ST_APPLIED;
            result_o.send_kind = tcsm_pkg::SK_ACK;
            result_o.send_seq  = send_next_q;
            result_o.send_ack  = recv_plus_one;
            recv_next_d        = recv_plus_one;
            if (phase_q == tcsm_pkg::PH_ESTAB) begin
              phase_d = tcsm_pkg::PH_CLOSE_WAIT;
            end else if (phase_q == tcsm_pkg::PH_FIN_WAIT1) begin
              phase_d = tcsm_pkg::PH_CLOSING;
            end else begin
              phase_d               = tcsm_pkg::PH_TIME_WAIT;
              linger_d              = item_i.now_ms;
              result_o.close_report = 1'b1;
            end
          end else begin
            result_o.status = tcsm_pkg::ST_IGNORED;
          end
        end
        default: begin
          // Peer ACK; the establish event was handled above.
          if (phase_q == tcsm_pkg::PH_FIN_WAIT1) begin
            phase_d         = tcsm_pkg::PH_FIN_WAIT2;
            result_o.status = tcsm_pkg::ST_APPLIED;
          end else if (phase_q == tcsm_pkg::PH_CLOSING) begin
            phase_d         = tcsm_pkg::PH_TIME_WAIT;
            linger_d        = item_i.now_ms;
            result_o.status = tcsm_pkg::ST_APPLIED;
          end else if (phase_q == tcsm_pkg::PH_LAST_ACK) begin
            result_o.status       = tcsm_pkg::ST_APPLIED;
            result_o.freed        = 1'b1;
            result_o.close_report = 1'b1;
            phase_d     = tcsm_pkg::PH_CLOSED;
            live_d      = 1'b0;
            send_next_d = '0;
            recv_next_d = '0;
            linger_d    = '0;
          end
        end
      endcase
    end

    result_o.conn_state      = phase_d;
    result_o.conn_live       = live_d;
    result_o.time_wait_stamp = linger_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tcsm_pkg::PH_CLOSED;
      live_q      <= 1'b0;
      send_next_q <= '0;
      recv_next_q <= '0;
      linger_q    <= '0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      live_q      <= live_d;
      send_next_q <= send_next_d;
      recv_next_q <= recv_next_d;
      linger_q    <= linger_d;
    end
  end

endmodule

@@ src/tcsm_result_stage.sv @@
// Result register for the TCP close-path state machine: holds one result
// item until the downstream side takes it. Depends on tcsm_pkg.
module tcsm_result_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  tcsm_pkg::result_t result_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcsm_pkg::result_t result_o
);

  logic              valid_q;
  tcsm_pkg::result_t result_q;

  assign can_load_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule
